/* rtl/kvlp_pkg.sv */
// Shared types, codes and character helpers for the key/value line parser.
package kvlp_pkg;

   localparam int LABEL_MAX_DEF = 16;
   localparam int VALUE_MAX_DEF = 40;

   // Result kinds
   localparam logic [1:0] KIND_LABEL = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_BAD   = 2'd3;

   // Characters with a special meaning
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_SUB  = 8'd26;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_DASH = 8'h2D;

   function automatic logic blank_char(input logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if ((c >= 8'h41) && (c <= 8'h5A)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

   // Controller to datapath commands
   typedef struct packed {
      logic       take_lab;   // take ch into the label buffer
      logic       take_val;   // take ch into the value buffer
      logic       first;      // the take starts a fresh buffer
      logic       clear;      // drop buffer counts and blank history
      logic       latch;      // capture finished lengths for readout
      logic       idx_clear;
      logic       idx_inc;
      logic       rd_lab;
      logic       rd_val;
      logic       load;       // load the output register
      logic [1:0] load_kind;
      logic       load_last;
      logic [7:0] ch;
   } kvlp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic lab_len_zero;   // finished label length is zero (live)
      logic val_len_zero;   // finished value length is zero (live)
      logic lab_at_end;     // readout index on the last label char
      logic val_at_end;     // readout index on the last value char
      logic emit_val_zero;  // captured value length is zero
      logic out_free;       // output register can take a request
   } kvlp_sts_type;

endpackage

/* rtl/kvlp_datapath.sv */
// Character buffers, length tracking, readout index and output register.
module kvlp_datapath import kvlp_pkg::*; #(
   parameter int LABEL_MAX = LABEL_MAX_DEF,
   parameter int VALUE_MAX = VALUE_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  kvlp_cmd_type cmd,
   output kvlp_sts_type sts,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [7:0]   rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int LCW = $clog2(LABEL_MAX + 1);
   localparam int VCW = $clog2(VALUE_MAX + 1);
   localparam int LAW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
   localparam int VAW = (VALUE_MAX > 1) ? $clog2(VALUE_MAX) : 1;
   localparam int IW  = (LCW > VCW) ? LCW : VCW;
   localparam int IXW = IW + 1;

   logic [7:0] label_mem [LABEL_MAX];
   logic [7:0] value_mem [VALUE_MAX];

   logic [LCW-1:0] lab_cnt_ff, lab_cnt_in, lab_nulpos_ff, lab_nulpos_in, lab_len_ff, lab_len_in;
   logic           lab_lastb_ff, lab_lastb_in, lab_nul_ff, lab_nul_in;
   logic [VCW-1:0] val_cnt_ff, val_cnt_in, val_nulpos_ff, val_nulpos_in, val_len_ff, val_len_in;
   logic           val_lastb_ff, val_lastb_in, val_nul_ff, val_nul_in;
   logic           prev_blank_ff, prev_blank_in;
   logic [IW-1:0]  idx_ff, idx_in;
   logic [7:0]     lab_rd_ff, val_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic [1:0]     rsp_kind_ff, rsp_kind_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           ch_blank, ch_nul, pb_eff;
   logic [LCW-1:0] lab_cnt_eff, lab_fin;
   logic [VCW-1:0] val_cnt_eff, val_fin;
   logic           lab_nul_eff, val_nul_eff, lab_store, val_store;

   always_comb begin
      ch_blank    = blank_char(cmd.ch);
      ch_nul      = (cmd.ch == CH_NUL);
      pb_eff      = cmd.first ? 1'b0 : prev_blank_ff;
      lab_cnt_eff = cmd.first ? '0 : lab_cnt_ff;
      val_cnt_eff = cmd.first ? '0 : val_cnt_ff;
      lab_nul_eff = cmd.first ? 1'b0 : lab_nul_ff;
      val_nul_eff = cmd.first ? 1'b0 : val_nul_ff;
      lab_store   = cmd.take_lab && !(pb_eff && ch_blank) && (lab_cnt_eff < LCW'(LABEL_MAX));
      val_store   = cmd.take_val && !(pb_eff && ch_blank) && (val_cnt_eff < VCW'(VALUE_MAX));

      // Finished length: drop one trailing blank, cut at the first NUL
      if (lab_nul_ff) begin
         lab_fin = lab_nulpos_ff;
      end else if ((lab_cnt_ff != '0) && lab_lastb_ff) begin
         lab_fin = lab_cnt_ff - 1'b1;
      end else begin
         lab_fin = lab_cnt_ff;
      end
      if (val_nul_ff) begin
         val_fin = val_nulpos_ff;
      end else if ((val_cnt_ff != '0) && val_lastb_ff) begin
         val_fin = val_cnt_ff - 1'b1;
      end else begin
         val_fin = val_cnt_ff;
      end
   end

   always_comb begin
      lab_cnt_in    = lab_cnt_ff;
      lab_lastb_in  = lab_lastb_ff;
      lab_nul_in    = lab_nul_ff;
      lab_nulpos_in = lab_nulpos_ff;
      val_cnt_in    = val_cnt_ff;
      val_lastb_in  = val_lastb_ff;
      val_nul_in    = val_nul_ff;
      val_nulpos_in = val_nulpos_ff;
      prev_blank_in = prev_blank_ff;
      lab_len_in    = lab_len_ff;
      val_len_in    = val_len_ff;
      idx_in        = idx_ff;

      if (cmd.clear) begin
         lab_cnt_in    = '0;
         val_cnt_in    = '0;
         lab_nul_in    = 1'b0;
         val_nul_in    = 1'b0;
         prev_blank_in = 1'b0;
      end
      if (cmd.take_lab) begin
         prev_blank_in = ch_blank;
         lab_cnt_in    = lab_cnt_eff;
         lab_nul_in    = lab_nul_eff;
         if (lab_store) begin
            lab_cnt_in   = lab_cnt_eff + 1'b1;
            lab_lastb_in = ch_blank;
            if (ch_nul && !lab_nul_eff) begin
               lab_nul_in    = 1'b1;
               lab_nulpos_in = lab_cnt_eff;
            end
         end
      end
      if (cmd.take_val) begin
         prev_blank_in = ch_blank;
         val_cnt_in    = val_cnt_eff;
         val_nul_in    = val_nul_eff;
         if (val_store) begin
            val_cnt_in   = val_cnt_eff + 1'b1;
            val_lastb_in = ch_blank;
            if (ch_nul && !val_nul_eff) begin
               val_nul_in    = 1'b1;
               val_nulpos_in = val_cnt_eff;
            end
         end
      end
      if (cmd.latch) begin
         lab_len_in = lab_fin;
         val_len_in = val_fin;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = cmd.load_kind;
         rsp_last_in  = cmd.load_last;
         if (cmd.load_kind == KIND_LABEL) begin
            rsp_data_in = to_lower(lab_rd_ff);
         end else if (cmd.load_kind == KIND_VALUE) begin
            rsp_data_in = val_rd_ff;
         end else begin
            rsp_data_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lab_cnt_ff    <= '0;
         lab_lastb_ff  <= 1'b0;
         lab_nul_ff    <= 1'b0;
         val_cnt_ff    <= '0;
         val_lastb_ff  <= 1'b0;
         val_nul_ff    <= 1'b0;
         prev_blank_ff <= 1'b0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         lab_cnt_ff    <= lab_cnt_in;
         lab_lastb_ff  <= lab_lastb_in;
         lab_nul_ff    <= lab_nul_in;
         val_cnt_ff    <= val_cnt_in;
         val_lastb_ff  <= val_lastb_in;
         val_nul_ff    <= val_nul_in;
         prev_blank_ff <= prev_blank_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lab_nulpos_ff <= lab_nulpos_in;
      val_nulpos_ff <= val_nulpos_in;
      lab_len_ff    <= lab_len_in;
      val_len_ff    <= val_len_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (lab_store) begin
         label_mem[lab_cnt_eff[LAW-1:0]] <= cmd.ch;
      end
      if (cmd.rd_lab) begin
         lab_rd_ff <= label_mem[idx_ff[LAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (val_store) begin
         value_mem[val_cnt_eff[VAW-1:0]] <= cmd.ch;
      end
      if (cmd.rd_val) begin
         val_rd_ff <= value_mem[idx_ff[VAW-1:0]];
      end
   end

   always_comb begin
      sts.lab_len_zero  = (lab_fin == '0);
      sts.val_len_zero  = (val_fin == '0);
      sts.lab_at_end    = ((IXW'(idx_ff) + 1'b1) == IXW'(lab_len_ff));
      sts.val_at_end    = ((IXW'(idx_ff) + 1'b1) == IXW'(val_len_ff));
      sts.emit_val_zero = (val_len_ff == '0);
      sts.out_free      = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/kvlp_controller.sv */
// Parse phase tracking and readout sequencing for the key/value line parser.
module kvlp_controller import kvlp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_mode,
   input  logic [7:0]   req_ch,
   input  kvlp_sts_type sts,
   output kvlp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LRD  = 3'd1;
   localparam logic [2:0] S_LOUT = 3'd2;
   localparam logic [2:0] S_VRD  = 3'd3;
   localparam logic [2:0] S_VOUT = 3'd4;
   localparam logic [2:0] S_STAT = 3'd5;

   localparam logic [2:0] PH_SKIP    = 3'd0;
   localparam logic [2:0] PH_COMMENT = 3'd1;
   localparam logic [2:0] PH_LABEL   = 3'd2;
   localparam logic [2:0] PH_PREVAL  = 3'd3;
   localparam logic [2:0] PH_VALUE   = 3'd4;
   localparam logic [2:0] PH_IGNORE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   logic       end_ff, end_in;
   logic [1:0] stat_ff, stat_in;
   logic       accept, ch_blank;
   logic [7:0] ch_m;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ch_m       = (req_ch == CH_SUB) ? CH_NL : req_ch;
   assign ch_blank   = blank_char(ch_m);

   always_comb begin
      cmd      = '0;
      cmd.ch   = ch_m;
      state_in = state_ff;
      phase_in = phase_ff;
      end_in   = end_ff;
      stat_in  = stat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_mode) begin
               // End of text: flush an open value, then report status
               cmd.clear     = 1'b1;
               cmd.latch     = 1'b1;
               cmd.idx_clear = 1'b1;
               phase_in      = PH_SKIP;
               end_in        = 1'b1;
               stat_in       = ((phase_ff == PH_LABEL) || (phase_ff == PH_PREVAL)) ?
                               KIND_BAD : KIND_DONE;
               if ((phase_ff == PH_VALUE) && !sts.lab_len_zero) begin
                  state_in = S_LRD;
               end else if ((phase_ff == PH_VALUE) && !sts.val_len_zero) begin
                  state_in = S_VRD;
               end else begin
                  state_in = S_STAT;
               end
            end else if (accept) begin
               unique case (phase_ff)
                  PH_COMMENT: begin
                     if (ch_m == CH_NL) begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_LABEL: begin
                     if ((ch_m == CH_EQ) || (ch_m == CH_DASH)) begin
                        phase_in = PH_PREVAL;
                     end else begin
                        cmd.take_lab = 1'b1;
                     end
                  end
                  PH_PREVAL: begin
                     if (!ch_blank) begin
                        cmd.take_val = 1'b1;
                        cmd.first    = 1'b1;
                        phase_in     = PH_VALUE;
                     end
                  end
                  PH_VALUE: begin
                     if (ch_m == CH_NL) begin
                        // Line end: read the setting out of the buffers that are not empty
                        cmd.clear     = 1'b1;
                        cmd.latch     = 1'b1;
                        cmd.idx_clear = 1'b1;
                        phase_in      = PH_SKIP;
                        end_in        = 1'b0;
                        if (!sts.lab_len_zero) begin
                           state_in = S_LRD;
                        end else if (!sts.val_len_zero) begin
                           state_in = S_VRD;
                        end
                     end else begin
                        cmd.take_val = 1'b1;
                     end
                  end
                  PH_IGNORE: begin
                  end
                  default: begin
                     if (ch_m == CH_NUL) begin
                        phase_in = PH_IGNORE;
                     end else if (ch_m == CH_HASH) begin
                        phase_in = PH_COMMENT;
                     end else if (!ch_blank) begin
                        cmd.take_lab = 1'b1;
                        cmd.first    = 1'b1;
                        phase_in     = PH_LABEL;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
               endcase
            end
         end
         S_LRD: begin
            cmd.rd_lab = 1'b1;
            state_in   = S_LOUT;
         end
         S_LOUT: begin
            if (sts.out_free) begin
               cmd.load      = 1'b1;
               cmd.load_kind = KIND_LABEL;
               cmd.load_last = sts.lab_at_end && sts.emit_val_zero && !end_ff;
               if (sts.lab_at_end) begin
                  cmd.idx_clear = 1'b1;
                  if (!sts.emit_val_zero) begin
                     state_in = S_VRD;
                  end else if (end_ff) begin
                     state_in = S_STAT;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_LRD;
               end
            end
         end
         S_VRD: begin
            cmd.rd_val = 1'b1;
            state_in   = S_VOUT;
         end
         S_VOUT: begin
            if (sts.out_free) begin
               cmd.load      = 1'b1;
               cmd.load_kind = KIND_VALUE;
               cmd.load_last = sts.val_at_end && !end_ff;
               if (sts.val_at_end) begin
                  state_in = end_ff ? S_STAT : S_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_VRD;
               end
            end
         end
         S_STAT: begin
            if (sts.out_free) begin
               cmd.load      = 1'b1;
               cmd.load_kind = stat_ff;
               cmd.load_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_SKIP;
         end_ff   <= 1'b0;
         stat_ff  <= KIND_DONE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         end_ff   <= end_in;
         stat_ff  <= stat_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.out_free)
      else $error("output register loaded while busy");

   a_stat_phase: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STAT) |-> (phase_ff == PH_SKIP))
      else $error("status pending with parse phase not restarted");

   a_latch_src: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> (accept && (req_mode || (phase_ff == PH_VALUE))))
      else $error("lengths captured outside a setting end");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !(cmd.take_lab || cmd.take_val))
      else $error("buffer written during readout");
`endif

endmodule

/* rtl/key_value_line_parser_core.sv */
// Top level of the key/value line parser: phase controller plus buffer datapath.
// A byte that ends no setting is taken while idle: one request per cycle between
// readouts. After a line end or end marker, each label or value char passes a
// buffer memory read, then an output register load, and a status one more load.
// Input stays stalled while a setting is read out of the buffer memories.
// Reset (synchronous, active high) clears phase, counts and the output valid.
module key_value_line_parser_core import kvlp_pkg::*; #(
   parameter int LABEL_MAX = LABEL_MAX_DEF,
   parameter int VALUE_MAX = VALUE_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tuser,   // [0] mode (1 = end of text)
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast
);

   kvlp_cmd_type cmd;
   kvlp_sts_type sts;

   // Controller owns the parse phase and sequences each readout
   kvlp_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_ch     (req_tdata),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath holds the buffers, length trackers and the output register
   kvlp_datapath #(
      .LABEL_MAX (LABEL_MAX),
      .VALUE_MAX (VALUE_MAX)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
